>>> rtl/core/ph160_pkg.sv
// shared types, constants and helper functions for the hash160 block
package ph160_pkg;

  // input transaction payload
  typedef struct packed {
    logic [63:0] key_word;
    logic [2:0]  word_index;
    logic        compressed;
  } ph160_in_t;

  // output transaction payload
  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } ph160_out_t;

  // controller phases
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHA_INIT,
    S_SHA_RUN,
    S_SHA_FIN,
    S_SHA_NEXT,
    S_RMD_RUN,
    S_RMD_FIN,
    S_OUT
  } ph160_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       store;
    logic       sha_init;
    logic       sha_round;
    logic       sha_fin;
    logic       sha_next;
    logic       rmd_round;
    logic       rmd_fin;
    logic [6:0] rnd;
    logic [2:0] oidx;
  } ph160_cmd_t;

  localparam logic [2:0] LAST_KEY_WORD   = 3'd7;
  localparam logic [2:0] LAST_DIGEST_WORD = 3'd4;
  localparam logic [6:0] SHA_LAST_ROUND  = 7'd63;
  localparam logic [6:0] RMD_LAST_ROUND  = 7'd79;

  localparam logic [7:0]  PFX_UNCOMP   = 8'h04;
  localparam logic [7:0]  PFX_ODD      = 8'h03;
  localparam logic [7:0]  PFX_EVEN     = 8'h02;
  localparam logic [7:0]  PAD_BYTE     = 8'h80;
  localparam logic [63:0] LEN_UNCOMP   = 64'd520;
  localparam logic [63:0] LEN_COMP     = 64'd264;
  localparam logic [31:0] RMD_PAD_WORD = 32'h0000_0080;
  localparam logic [31:0] RMD_LEN_WORD = 32'h0000_0100;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] RMD_IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam logic [31:0] RMD_KL [5] = '{
    32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'ha953fd4e
  };
  localparam logic [31:0] RMD_KR [5] = '{
    32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h7a6d76e9, 32'h00000000
  };

  localparam int RMD_RL [80] = '{
    0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15, 7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
    3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12, 1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
    4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13
  };
  localparam int RMD_RR [80] = '{
    5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12, 6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
    15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13, 8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
    12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11
  };
  localparam int RMD_SL [80] = '{
    11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8, 7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
    11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5, 11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
    9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6
  };
  localparam int RMD_SR [80] = '{
    8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6, 9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
    9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5, 15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
    8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11
  };

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // ripemd boolean function of round group 0..4
  function automatic logic [31:0] rmd_f(input logic [2:0] g, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
    logic [31:0] r;
    case (g)
      3'd0:    r = x ^ y ^ z;
      3'd1:    r = (x & y) | (~x & z);
      3'd2:    r = (x | ~y) ^ z;
      3'd3:    r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/ph160_ctrl.sv
// controller state machine: sequences sha-256 blocks, ripemd-160 and output words
module ph160_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [2:0]            in_index,
  input  logic                  in_compressed,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ph160_pkg::ph160_cmd_t cmd
);
  import ph160_pkg::*;

  ph160_state_t state_r, state_nxt;
  logic [6:0]   rnd_r, rnd_nxt;
  logic         cmp_r, cmp_nxt;
  logic         blk_r, blk_nxt;
  logic [2:0]   oidx_r, oidx_nxt;
  logic         acc;

  assign acc = in_valid && in_ready;

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    cmp_nxt   = cmp_r;
    blk_nxt   = blk_r;
    oidx_nxt  = oidx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_index == LAST_KEY_WORD) begin
          state_nxt = S_SHA_INIT;
          cmp_nxt   = in_compressed;
          blk_nxt   = 1'b0;
        end
      end
      S_SHA_INIT, S_SHA_NEXT: begin
        state_nxt = S_SHA_RUN;
        rnd_nxt   = '0;
      end
      S_SHA_RUN: begin
        if (rnd_r == SHA_LAST_ROUND) begin
          state_nxt = S_SHA_FIN;
          rnd_nxt   = '0;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      S_SHA_FIN: begin
        if (cmp_r || blk_r) begin
          state_nxt = S_RMD_RUN;
        end else begin
          state_nxt = S_SHA_NEXT;
          blk_nxt   = 1'b1;
        end
        rnd_nxt = '0;
      end
      S_RMD_RUN: begin
        if (rnd_r == RMD_LAST_ROUND) begin
          state_nxt = S_RMD_FIN;
          rnd_nxt   = '0;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      S_RMD_FIN: begin
        state_nxt = S_OUT;
        oidx_nxt  = '0;
      end
      S_OUT: begin
        if (out_ready) begin
          if (oidx_r == LAST_DIGEST_WORD) begin
            state_nxt = S_IDLE;
          end else begin
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready      = (state_r == S_IDLE) && rst_n;
    out_valid     = (state_r == S_OUT);
    cmd           = '0;
    cmd.store     = acc;
    cmd.sha_init  = (state_r == S_SHA_INIT);
    cmd.sha_round = (state_r == S_SHA_RUN);
    cmd.sha_fin   = (state_r == S_SHA_FIN);
    cmd.sha_next  = (state_r == S_SHA_NEXT);
    cmd.rmd_round = (state_r == S_RMD_RUN);
    cmd.rmd_fin   = (state_r == S_RMD_FIN);
    cmd.rnd       = rnd_r;
    cmd.oidx      = oidx_r;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r   <= '0;
      cmp_r   <= 1'b0;
      blk_r   <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      cmp_r   <= cmp_nxt;
      blk_r   <= blk_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_word_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_index == LAST_KEY_WORD) |=> state_r == S_SHA_INIT)
    else $error("last key word did not start hashing");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("input taken while digest pending");
  a_sha_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHA_RUN |-> rnd_r <= SHA_LAST_ROUND)
    else $error("sha round counter out of range");
  a_out_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> oidx_r <= LAST_DIGEST_WORD)
    else $error("digest word index out of range");
  a_second_block_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHA_NEXT |-> !cmp_r)
    else $error("second sha block for compressed key");
`endif
endmodule

>>> rtl/core/ph160_dp.sv
// datapath: key store, sha-256 round unit, ripemd-160 round unit, digest register
module ph160_dp (
  input  logic                  clk,
  input  ph160_pkg::ph160_cmd_t cmd,
  input  ph160_pkg::ph160_in_t  in_data,
  output ph160_pkg::ph160_out_t out_data
);
  import ph160_pkg::*;

  logic [63:0]  ks_r [8];
  logic [31:0]  sh_r [8];
  logic [31:0]  wv_r [8];
  logic [31:0]  w_r  [16];
  logic [31:0]  rl_r [5];
  logic [31:0]  rr_r [5];
  logic [31:0]  dg_r [5];

  // form flag taken with the last key word
  logic cmp_r;

  logic [511:0] key_bits;
  logic [511:0] blk0, blk1;
  logic [7:0]   pfx;

  // message blocks built from the stored key
  always_comb begin
    key_bits = {ks_r[0], ks_r[1], ks_r[2], ks_r[3], ks_r[4], ks_r[5], ks_r[6], ks_r[7]};
    pfx      = ks_r[7][0] ? PFX_ODD : PFX_EVEN;
    if (cmp_r) begin
      blk0 = {pfx, key_bits[511:256], PAD_BYTE, 176'b0, LEN_COMP};
    end else begin
      blk0 = {PFX_UNCOMP, key_bits[511:8]};
    end
    blk1 = {key_bits[7:0], PAD_BYTE, 432'b0, LEN_UNCOMP};
  end

  // sha-256 round
  logic [31:0] s1e, ch, s0a, maj, t1, t2, wnew, ws0, ws1;
  always_comb begin
    s1e  = rotr32(wv_r[4], 5'd6) ^ rotr32(wv_r[4], 5'd11) ^ rotr32(wv_r[4], 5'd25);
    ch   = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    t1   = wv_r[7] + s1e + ch + SHA_K[cmd.rnd[5:0]] + w_r[0];
    s0a  = rotr32(wv_r[0], 5'd2) ^ rotr32(wv_r[0], 5'd13) ^ rotr32(wv_r[0], 5'd22);
    maj  = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    t2   = s0a + maj;
    ws0  = rotr32(w_r[1], 5'd7) ^ rotr32(w_r[1], 5'd18) ^ (w_r[1] >> 3);
    ws1  = rotr32(w_r[14], 5'd17) ^ rotr32(w_r[14], 5'd19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + ws0 + w_r[9] + ws1;
  end

  // ripemd-160 message word select
  function automatic logic [31:0] rmd_x(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0:    r = bswap32(sh_r[0]);
      4'd1:    r = bswap32(sh_r[1]);
      4'd2:    r = bswap32(sh_r[2]);
      4'd3:    r = bswap32(sh_r[3]);
      4'd4:    r = bswap32(sh_r[4]);
      4'd5:    r = bswap32(sh_r[5]);
      4'd6:    r = bswap32(sh_r[6]);
      4'd7:    r = bswap32(sh_r[7]);
      4'd8:    r = RMD_PAD_WORD;
      4'd14:   r = RMD_LEN_WORD;
      default: r = '0;
    endcase
    return r;
  endfunction

  // ripemd-160 round, both lanes
  logic [2:0]  gl, gr;
  logic [31:0] tl, tr;
  always_comb begin
    gl = cmd.rnd[6:4];
    gr = 3'd4 - gl;
    tl = rotl32(rl_r[0] + rmd_f(gl, rl_r[1], rl_r[2], rl_r[3]) + rmd_x(4'(RMD_RL[cmd.rnd]))
                + RMD_KL[gl], 5'(RMD_SL[cmd.rnd])) + rl_r[4];
    tr = rotl32(rr_r[0] + rmd_f(gr, rr_r[1], rr_r[2], rr_r[3]) + rmd_x(4'(RMD_RR[cmd.rnd]))
                + RMD_KR[gl], 5'(RMD_SR[cmd.rnd])) + rr_r[4];
  end

  // key store and form flag
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ks_r[in_data.word_index] <= in_data.key_word;
      if (in_data.word_index == LAST_KEY_WORD) begin
        cmp_r <= in_data.compressed;
      end
    end
  end

  // sha-256 state and schedule
  always_ff @(posedge clk) begin
    if (cmd.sha_init) begin
      for (int i = 0; i < 8; i++) begin
        sh_r[i] <= SHA_IV[i];
        wv_r[i] <= SHA_IV[i];
      end
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= blk0[511 - 32*i -: 32];
      end
    end else if (cmd.sha_next) begin
      for (int i = 0; i < 8; i++) begin
        wv_r[i] <= sh_r[i];
      end
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= blk1[511 - 32*i -: 32];
      end
    end else if (cmd.sha_round) begin
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= wnew;
    end else if (cmd.sha_fin) begin
      for (int i = 0; i < 8; i++) begin
        sh_r[i] <= sh_r[i] + wv_r[i];
      end
    end
  end

  // ripemd-160 lanes and digest
  always_ff @(posedge clk) begin
    if (cmd.sha_fin) begin
      for (int i = 0; i < 5; i++) begin
        rl_r[i] <= RMD_IV[i];
        rr_r[i] <= RMD_IV[i];
      end
    end else if (cmd.rmd_round) begin
      rl_r[0] <= rl_r[4];
      rl_r[1] <= tl;
      rl_r[2] <= rl_r[1];
      rl_r[3] <= rotl32(rl_r[2], 5'd10);
      rl_r[4] <= rl_r[3];
      rr_r[0] <= rr_r[4];
      rr_r[1] <= tr;
      rr_r[2] <= rr_r[1];
      rr_r[3] <= rotl32(rr_r[2], 5'd10);
      rr_r[4] <= rr_r[3];
    end
    if (cmd.rmd_fin) begin
      dg_r[0] <= RMD_IV[1] + rl_r[2] + rr_r[3];
      dg_r[1] <= RMD_IV[2] + rl_r[3] + rr_r[4];
      dg_r[2] <= RMD_IV[3] + rl_r[4] + rr_r[0];
      dg_r[3] <= RMD_IV[4] + rl_r[0] + rr_r[1];
      dg_r[4] <= RMD_IV[0] + rl_r[1] + rr_r[2];
    end
  end

  // output word select
  always_comb begin
    case (cmd.oidx)
      3'd0:    out_data.digest_word = bswap32(dg_r[0]);
      3'd1:    out_data.digest_word = bswap32(dg_r[1]);
      3'd2:    out_data.digest_word = bswap32(dg_r[2]);
      3'd3:    out_data.digest_word = bswap32(dg_r[3]);
      default: out_data.digest_word = bswap32(dg_r[4]);
    endcase
    out_data.digest_last = (cmd.oidx == LAST_DIGEST_WORD);
  end
endmodule

>>> rtl/core/public_key_hash160.sv
// top level: hash160 of a public key, controller plus datapath
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | ph160_in_t (key_word, word_index, compressed)
//  out_    | output    | out_valid/out_ready | ph160_out_t (digest_word, digest_last)
//
// key words 0..6 are stored as they are accepted; word 7 is stored and starts the hash.
// compressed key: sha init, 64 sha rounds and a finish step, 80 ripemd rounds and a finish
// step, then 5 output words. uncompressed key adds a second sha block: reload, 64 rounds, finish.
// each hash unit runs one round per cycle.
// rst_n is synchronous; a stalled out_ready holds the current digest word and input.
module public_key_hash160 (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ph160_pkg::ph160_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ph160_pkg::ph160_out_t out_data
);
  import ph160_pkg::*;

  ph160_cmd_t cmd;

  // sequencing
  ph160_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_index      (in_data.word_index),
    .in_compressed (in_data.compressed),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cmd           (cmd)
  );

  // hashing datapath
  ph160_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );
endmodule
